FILE: sv/rstg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstg_pkg
// Opcodes, register indexes and fixed constants of the render scale tier
// governor.
// ----------------------------------------------------------------------------
package rstg_pkg;

    // opcodes of an input transaction
    localparam logic [2:0] OP_FRAME    = 3'd0;
    localparam logic [2:0] OP_FORCE    = 3'd1;
    localparam logic [2:0] OP_LOCK     = 3'd2;
    localparam logic [2:0] OP_UNLOCK   = 3'd3;
    localparam logic [2:0] OP_SHUTDOWN = 3'd4;
    localparam logic [2:0] OP_RESTART  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_SCALE      = 3'd0;
    localparam logic [2:0] CFG_KMAX       = 3'd1;
    localparam logic [2:0] CFG_DOWN_FRAMES = 3'd2;
    localparam logic [2:0] CFG_UP_FRAMES  = 3'd3;
    localparam logic [2:0] CFG_DOWN_THR   = 3'd4;
    localparam logic [2:0] CFG_UP_THR     = 3'd5;
    localparam logic [2:0] CFG_START      = 3'd6;

    // register reset values
    localparam logic [16:0] RST_SCALE       = 17'd21627;
    localparam logic [10:0] RST_KMAX        = 11'd512;
    localparam logic [9:0]  RST_DOWN_FRAMES = 10'd30;
    localparam logic [9:0]  RST_UP_FRAMES   = 10'd60;
    localparam logic [16:0] RST_DOWN_THR    = 17'd62259;
    localparam logic [16:0] RST_UP_THR      = 17'd68813;

    localparam logic [9:0]  CNT_MAX    = 10'd1023;
    localparam logic [10:0] K_BASE     = 11'd256;
    // interval numerators: 1e6 us << 24 with fps, 6060 us << 16 without
    localparam logic [23:0] US_PER_S   = 24'd1000000;
    localparam logic [23:0] DEF_US     = 24'd6060;
    localparam logic [39:0] WINDOW_US  = 40'd5000000;
    localparam logic [41:0] SPIKE_NUM  = 42'd512000000;
    localparam logic [23:0] SPIKE_DEF  = 24'd33334;
    localparam logic [41:0] HALF_Q24   = 42'd8388608;

    typedef struct packed {
        logic [39:0] ts;
        logic [23:0] ft;
    } t_hist_entry;

endpackage

FILE: sv/rstg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rstg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/render_scale_tier_governor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// render_scale_tier_governor_core
// Per-frame quality tier governor with slow/fast frame counters, a quality
// floor and a spike lock over a logged transition history.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (i_valid / o_stall) takes one op per transaction: a frame
//    report, force tier, lock, unlock, shutdown or restart
//  - output channel (o_valid / i_stall) returns exactly one result per op
//  - registers are written over i_cfg_valid / o_cfg_ready while idle
//  - one transaction at a time: the next op is accepted only after the
//    current op's result is loaded; a frame runs extra states (fewer when
//    locked), more when the quality floor is checked and for each floor
//    step, and more when the history (n entries) is scanned; the single
//    shared 24x18 multiplier and the history RAM read port set this sequence
//  - the next op is taken as soon as the result sits in the output register
//  - a stalled result holds; the sequencer waits in its last state until
//    the output register is free
//  - reset restores the register defaults, tier 0, active, unlocked, empty
//    history; history RAM contents are not cleared (only written entries
//    are ever read)
// ----------------------------------------------------------------------------
module render_scale_tier_governor_core
    import rstg_pkg::*;
#(
    parameter int MAX_TIERS     = 16,
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [2:0]                   i_op,
    input  logic [23:0]                  i_frame_time_us,
    input  logic [17:0]                  i_target_fps,
    input  logic                         i_fg_active,
    input  logic [3:0]                   i_fg_multiplier,
    input  logic                         i_rr_active,
    input  logic [7:0]                   i_tier_index,
    // output channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_transitioned,
    output logic [$clog2(MAX_TIERS)-1:0] o_tier,
    output logic [10:0]                  o_tier_k,
    output logic [18:0]                  o_quality,
    output logic                         o_locked_flag,
    output logic                         o_active_flag,
    // configuration
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [2:0]                   i_cfg_index,
    input  logic [16:0]                  i_cfg_data
);

    localparam int TW = $clog2(MAX_TIERS);
    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DEC   = 5'd1;
    localparam logic [4:0] S_F0    = 5'd2;
    localparam logic [4:0] S_MP    = 5'd3;
    localparam logic [4:0] S_DL    = 5'd4;
    localparam logic [4:0] S_DH    = 5'd5;
    localparam logic [4:0] S_UL    = 5'd6;
    localparam logic [4:0] S_UH    = 5'd7;
    localparam logic [4:0] S_CMPU  = 5'd8;
    localparam logic [4:0] S_CNT   = 5'd9;
    localparam logic [4:0] S_STEP  = 5'd10;
    localparam logic [4:0] S_RRM   = 5'd11;
    localparam logic [4:0] S_RRC   = 5'd12;
    localparam logic [4:0] S_LOG   = 5'd13;
    localparam logic [4:0] S_SA    = 5'd14;
    localparam logic [4:0] S_SB    = 5'd15;
    localparam logic [4:0] S_LOCK  = 5'd16;
    localparam logic [4:0] S_Q     = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;

    function automatic logic [TW-1:0] last_of(input logic [10:0] km);
        logic [6:0] d;
        d = 7'((km - K_BASE) >> 6);
        if (km < K_BASE) begin
            return '0;
        end else if (d > 7'(MAX_TIERS - 1)) begin
            return TW'(MAX_TIERS - 1);
        end else begin
            return TW'(d);
        end
    endfunction

    // state and registers
    logic [4:0]  r_state;
    logic [16:0] r_scale;
    logic [10:0] r_kmax;
    logic [9:0]  r_down_frames;
    logic [9:0]  r_up_frames;
    logic [16:0] r_down_thr;
    logic [16:0] r_up_thr;
    logic [3:0]  r_start;

    logic [2:0]  r_op;
    logic [23:0] r_ft;
    logic [17:0] r_fps;
    logic        r_fga;
    logic [3:0]  r_fgm;
    logic        r_rr;
    logic [7:0]  r_tidx;

    logic [TW-1:0] r_tier;
    logic [TW-1:0] r_prev;
    logic [9:0]  r_slow;
    logic [9:0]  r_fast;
    logic        r_locked;
    logic        r_active;
    logic [39:0] r_elapsed;
    logic [CW-1:0] r_hcnt;
    logic [HW-1:0] r_wptr;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_spk;
    logic        r_pend;
    logic        r_inwin;
    logic [23:0] r_eft;
    logic [39:0] r_wstart;
    logic        r_trans;

    logic [41:0] r_prod;
    logic [41:0] r_p;
    logic [41:0] r_acc;
    logic [58:0] r_lhs_d;
    logic [47:0] r_rhs;

    logic          r_ovalid;
    logic          r_otrans;
    logic [TW-1:0] r_otier;
    logic [10:0]   r_ok;
    logic [18:0]   r_oq;
    logic          r_olocked;
    logic          r_oactive;

    // combinational helpers
    logic [TW-1:0] last;
    logic [10:0]   k_cur;
    logic [23:0]   mul_a;
    logic [17:0]   mul_b;
    logic [58:0]   lhs_u;
    logic [40:0]   el_sum;
    logic [3:0]    m_fac;
    logic [23:0]   rhs_base;
    logic          trans_now;
    logic [CW-1:0] hcnt_new;
    logic          spike;
    logic          out_free;
    logic          out_load;
    logic [63:0]   ram_rdata;
    t_hist_entry   wr_entry;
    t_hist_entry   rd_entry;

    assign last  = last_of(r_kmax);
    assign k_cur = (r_tier >= last) ? r_kmax : 11'(12'd256 + (12'(r_tier) << 6));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MP: begin
                mul_a = r_ft;
                mul_b = (r_fps == '0) ? 18'd1 : r_fps;
            end
            S_DL: begin
                mul_a = r_prod[23:0];
                mul_b = 18'(r_down_thr);
            end
            S_DH: begin
                mul_a = 24'(r_down_thr);
                mul_b = r_p[41:24];
            end
            S_UL: begin
                mul_a = r_p[23:0];
                mul_b = 18'(r_up_thr);
            end
            S_UH: begin
                mul_a = 24'(r_up_thr);
                mul_b = r_p[41:24];
            end
            // quality product held while the result waits
            S_RRM, S_Q, S_OUT: begin
                mul_a = 24'(r_scale);
                mul_b = 18'(k_cur);
            end
            S_SB: begin
                mul_a = rd_entry.ft;
                mul_b = r_fps;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign lhs_u    = 59'(r_acc) + (59'(r_prod) << 24);
    assign el_sum   = {1'b0, r_elapsed} + 41'(r_ft);
    assign m_fac    = (r_fga && r_fgm > 4'd1) ? r_fgm : 4'd1;
    assign rhs_base = (r_fps == '0) ? 24'(DEF_US * m_fac) : 24'(US_PER_S * m_fac);
    assign trans_now = r_trans || (r_tier != r_prev);
    assign hcnt_new = (r_hcnt < CW'(HISTORY_DEPTH)) ? r_hcnt + 1'b1 : r_hcnt;
    assign spike    = (r_fps == '0) ? (r_eft > SPIKE_DEF) : (r_prod > SPIKE_NUM);
    assign out_free = !r_ovalid || !i_stall;
    assign out_load = (r_state == S_OUT) && out_free;

    assign wr_entry.ts = r_elapsed;
    assign wr_entry.ft = r_ft;
    assign rd_entry    = t_hist_entry'(ram_rdata);

    rstg_ram #(
        .WIDTH(64),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (r_state == S_LOG && trans_now),
        .i_waddr(r_wptr),
        .i_wdata(wr_entry),
        .i_raddr(r_idx[HW-1:0]),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= 42'(mul_a * mul_b);
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_scale       <= RST_SCALE;
            r_kmax        <= RST_KMAX;
            r_down_frames <= RST_DOWN_FRAMES;
            r_up_frames   <= RST_UP_FRAMES;
            r_down_thr    <= RST_DOWN_THR;
            r_up_thr      <= RST_UP_THR;
            r_start       <= '0;
            r_tier        <= '0;
            r_slow        <= '0;
            r_fast        <= '0;
            r_locked      <= 1'b0;
            r_active      <= 1'b1;
            r_elapsed     <= '0;
            r_hcnt        <= '0;
            r_wptr        <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SCALE:       r_scale       <= i_cfg_data;
                    CFG_KMAX: begin
                        r_kmax <= i_cfg_data[10:0];
                        if (r_tier > last_of(i_cfg_data[10:0])) begin
                            r_tier <= last_of(i_cfg_data[10:0]);
                        end
                    end
                    CFG_DOWN_FRAMES: r_down_frames <= i_cfg_data[9:0];
                    CFG_UP_FRAMES:   r_up_frames   <= i_cfg_data[9:0];
                    CFG_DOWN_THR:    r_down_thr    <= i_cfg_data;
                    CFG_UP_THR:      r_up_thr      <= i_cfg_data;
                    CFG_START:       r_start       <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_op;
                        r_ft    <= i_frame_time_us;
                        r_fps   <= i_target_fps;
                        r_fga   <= i_fg_active;
                        r_fgm   <= i_fg_multiplier;
                        r_rr    <= i_rr_active;
                        r_tidx  <= i_tier_index;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_trans <= 1'b0;
                    r_prev  <= r_tier;
                    r_state <= (r_op == OP_FRAME && r_active) ? S_F0 : S_Q;
                    case (r_op)
                        OP_FORCE: begin
                            if (r_active) begin
                                r_tier <= (r_tidx > 8'(last)) ? last : TW'(r_tidx);
                                r_slow <= '0;
                                r_fast <= '0;
                            end
                        end
                        OP_LOCK:   r_locked <= 1'b1;
                        OP_UNLOCK: r_locked <= 1'b0;
                        OP_SHUTDOWN, OP_RESTART: begin
                            r_active  <= (r_op == OP_RESTART);
                            if (r_op == OP_RESTART) begin
                                r_tier <= (8'(r_start) > 8'(last)) ? last : TW'(r_start);
                            end else begin
                                r_tier <= '0;
                            end
                            r_slow    <= '0;
                            r_fast    <= '0;
                            r_locked  <= 1'b0;
                            r_hcnt    <= '0;
                            r_wptr    <= '0;
                            r_elapsed <= '0;
                        end
                        default: ;
                    endcase
                end
                S_F0: begin
                    r_elapsed <= el_sum[40] ? '1 : el_sum[39:0];
                    r_rhs     <= (r_fps == '0) ? (48'(rhs_base) << 16)
                                               : (48'(rhs_base) << 24);
                    r_state   <= r_locked ? S_Q : S_MP;
                end
                S_MP: r_state <= S_DL;
                S_DL: begin
                    r_p     <= r_prod;
                    r_state <= S_DH;
                end
                S_DH: begin
                    r_acc   <= r_prod;
                    r_state <= S_UL;
                end
                S_UL: begin
                    r_lhs_d <= 59'(r_acc) + (59'(r_prod) << 24);
                    r_state <= S_UH;
                end
                S_UH: begin
                    r_acc   <= r_prod;
                    r_state <= S_CMPU;
                end
                S_CMPU: begin
                    // r_p reused to hold the fast compare result; r_acc is cleared
                    r_acc   <= '0;
                    r_p     <= 42'(lhs_u < 59'(r_rhs));
                    r_state <= S_CNT;
                end
                S_CNT: begin
                    if (r_lhs_d > 59'(r_rhs)) begin
                        if (r_slow < CNT_MAX) r_slow <= r_slow + 1'b1;
                        r_fast <= '0;
                    end else if (r_p[0]) begin
                        if (r_fast < CNT_MAX) r_fast <= r_fast + 1'b1;
                        r_slow <= '0;
                    end else begin
                        r_slow <= '0;
                        r_fast <= '0;
                    end
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (r_slow >= r_down_frames && r_tier > '0) begin
                        r_tier  <= r_tier - 1'b1;
                        r_slow  <= '0;
                        r_fast  <= '0;
                        r_trans <= 1'b1;
                    end else if (r_fast >= r_up_frames && r_tier < last) begin
                        r_tier  <= r_tier + 1'b1;
                        r_slow  <= '0;
                        r_fast  <= '0;
                        r_trans <= 1'b1;
                    end
                    r_state <= r_rr ? S_RRM : S_LOG;
                end
                S_RRM: r_state <= S_RRC;
                S_RRC: begin
                    // quality floor: climb while scale*k is below one half
                    if (r_tier < last && r_prod < HALF_Q24) begin
                        r_tier  <= r_tier + 1'b1;
                        r_state <= S_RRM;
                    end else begin
                        r_state <= S_LOG;
                    end
                end
                S_LOG: begin
                    r_trans <= trans_now;
                    r_state <= (trans_now && hcnt_new >= CW'(3)) ? S_SA : S_Q;
                    if (trans_now) begin
                        r_hcnt   <= hcnt_new;
                        r_wptr   <= (r_wptr == HW'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
                        r_wstart <= (r_elapsed >= WINDOW_US) ? r_elapsed - WINDOW_US : '0;
                        r_idx    <= '0;
                        r_spk    <= '0;
                        r_pend   <= 1'b0;
                    end
                end
                S_SA: begin
                    if (r_pend && r_inwin && spike) begin
                        r_spk <= r_spk + 1'b1;
                    end
                    r_pend  <= 1'b0;
                    r_state <= (r_idx == r_hcnt) ? S_LOCK : S_SB;
                end
                S_SB: begin
                    r_inwin <= (rd_entry.ts >= r_wstart);
                    r_eft   <= rd_entry.ft;
                    r_pend  <= 1'b1;
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_SA;
                end
                S_LOCK: begin
                    if (r_spk >= CW'(3)) begin
                        r_locked <= 1'b1;
                    end
                    r_state <= S_Q;
                end
                S_Q: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_otrans  <= r_trans;
                        r_otier   <= r_tier;
                        r_ok      <= r_active ? k_cur : K_BASE;
                        r_oq      <= r_active ? r_prod[26:8] : '0;
                        r_olocked <= r_locked;
                        r_oactive <= r_active;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_transitioned = r_otrans;
    assign o_tier         = r_otier;
    assign o_tier_k       = r_ok;
    assign o_quality      = r_oq;
    assign o_locked_flag  = r_olocked;
    assign o_active_flag  = r_oactive;

    // tier never passes the last tier
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_tier <= last)
        else $error("tier above last tier");

    // a shut down governor sits at tier 0
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !r_active |-> r_tier == '0)
        else $error("inactive governor with nonzero tier");

    // history fill never exceeds its depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= CW'(HISTORY_DEPTH))
        else $error("history count overflow");

    // a stalled result is held, not dropped
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> r_ovalid)
        else $error("stalled result dropped");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the render scale tier governor: directed and
// random op sequences with random gaps on both channels, checked against a
// cycle-free prediction of transition, tier, k, quality, lock and active state.
// ----------------------------------------------------------------------------
module tb_top
    import rstg_pkg::*;
();

    localparam int TIERS = 16;
    localparam int HDEPTH = 16;

    typedef struct packed {
        logic        trans;
        logic [3:0]  tier;
        logic [10:0] tier_k;
        logic [18:0] quality;
        logic        locked;
        logic        active;
    } gov_result_t;

    class tier_scoreboard;
        logic [16:0] scale;
        logic [10:0] kmax;
        logic [9:0]  down_n;
        logic [9:0]  up_n;
        logic [16:0] down_thr;
        logic [16:0] up_thr;
        logic [3:0]  start_t;
        int unsigned cur;
        int unsigned slow_cnt;
        int unsigned fast_cnt;
        bit          lk;
        bit          act;
        logic [63:0] elapsed;
        logic [63:0] hist_ts[HDEPTH];
        logic [23:0] hist_ft[HDEPTH];
        int unsigned hcount;
        gov_result_t pending[$];
        int          errors;

        function new();
            scale = RST_SCALE; kmax = RST_KMAX; down_n = RST_DOWN_FRAMES;
            up_n = RST_UP_FRAMES; down_thr = RST_DOWN_THR; up_thr = RST_UP_THR;
            start_t = 0; cur = 0; act = 1; errors = 0;
            clear_run();
        endfunction

        function void clear_run();
            slow_cnt = 0; fast_cnt = 0; lk = 0; hcount = 0; elapsed = 0;
        endfunction

        function int unsigned top_tier();
            int unsigned n;
            if (kmax < 256) return 0;
            n = (kmax - 256) / 64 + 1;
            if (n > TIERS) n = TIERS;
            return n - 1;
        endfunction

        function int unsigned k_of(int unsigned t);
            if (t >= top_tier()) return kmax;
            return 256 + 64 * t;
        endfunction

        function void write_reg(logic [2:0] idx, logic [16:0] v);
            case (idx)
                CFG_SCALE: scale = v;
                CFG_KMAX: begin
                    kmax = v[10:0];
                    if (cur > top_tier()) cur = top_tier();
                end
                CFG_DOWN_FRAMES: down_n = v[9:0];
                CFG_UP_FRAMES: up_n = v[9:0];
                CFG_DOWN_THR: down_thr = v;
                CFG_UP_THR: up_thr = v;
                CFG_START: start_t = v[3:0];
                default: ;
            endcase
        endfunction

        function bit frame(logic [23:0] ft, logic [17:0] fps, bit fg, logic [3:0] fgm,
                           bit rr);
            logic [127:0] rhs, ld, lu;
            logic [63:0] m, wstart;
            int unsigned prev, last, spikes;
            bit tr, spk;
            tr = 0;
            last = top_tier();
            elapsed = elapsed + ft;
            if (elapsed > 64'hFF_FFFF_FFFF) elapsed = 64'hFF_FFFF_FFFF;
            if (lk) return 0;
            m = (fg && fgm > 1) ? fgm : 1;
            if (fps == 0) begin
                rhs = 128'd6060 * 128'd65536 * m;
                ld = 128'(ft) * down_thr;
                lu = 128'(ft) * up_thr;
            end else begin
                rhs = 128'd16777216000000 * m;
                ld = 128'(ft) * fps * down_thr;
                lu = 128'(ft) * fps * up_thr;
            end
            if (ld > rhs) begin
                if (slow_cnt < 1023) slow_cnt++;
                fast_cnt = 0;
            end else if (lu < rhs) begin
                if (fast_cnt < 1023) fast_cnt++;
                slow_cnt = 0;
            end else begin
                slow_cnt = 0; fast_cnt = 0;
            end
            prev = cur;
            if (slow_cnt >= down_n && cur > 0) begin
                cur--; slow_cnt = 0; fast_cnt = 0; tr = 1;
            end else if (fast_cnt >= up_n && cur < last) begin
                cur++; slow_cnt = 0; fast_cnt = 0; tr = 1;
            end
            if (rr) begin
                while (cur < last && 64'(scale) * k_of(cur) < 64'd8388608) cur++;
                if (cur != prev) tr = 1;
            end
            if (tr) begin
                if (hcount < HDEPTH) begin
                    hist_ts[hcount] = elapsed; hist_ft[hcount] = ft; hcount++;
                end else begin
                    for (int i = 0; i < HDEPTH - 1; i++) begin
                        hist_ts[i] = hist_ts[i+1]; hist_ft[i] = hist_ft[i+1];
                    end
                    hist_ts[HDEPTH-1] = elapsed; hist_ft[HDEPTH-1] = ft;
                end
                if (hcount >= 3) begin
                    wstart = elapsed >= 5000000 ? elapsed - 5000000 : 0;
                    spikes = 0;
                    for (int i = 0; i < hcount; i++) begin
                        if (fps == 0) spk = hist_ft[i] > 33334;
                        else spk = 64'(hist_ft[i]) * fps > 64'd512000000;
                        if (hist_ts[i] >= wstart && spk) spikes++;
                    end
                    if (spikes >= 3) lk = 1;
                end
            end
            return tr;
        endfunction

        function void note_op(logic [2:0] op, logic [23:0] ft, logic [17:0] fps, bit fg,
                              logic [3:0] fgm, bit rr, logic [7:0] ti);
            gov_result_t r;
            int unsigned last;
            r = '0;
            last = top_tier();
            case (op)
                OP_FRAME: if (act) r.trans = frame(ft, fps, fg, fgm, rr);
                OP_FORCE: if (act) begin
                    cur = ti > last ? last : ti;
                    slow_cnt = 0; fast_cnt = 0;
                end
                OP_LOCK: lk = 1;
                OP_UNLOCK: lk = 0;
                OP_SHUTDOWN: begin
                    act = 0; cur = 0; clear_run();
                end
                OP_RESTART: begin
                    cur = start_t > last ? last : start_t;
                    clear_run(); act = 1;
                end
                default: ;
            endcase
            r.tier = 4'(cur);
            r.tier_k = act ? 11'(k_of(cur)) : 11'd256;
            r.quality = act ? 19'((64'(scale) * k_of(cur)) >> 8) : 19'd0;
            r.locked = lk;
            r.active = act;
            pending = {pending, r};
        endfunction

        function void check(gov_result_t got);
            gov_result_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_valid = 0, i_stall = 0;
    logic [2:0]  i_op = 0;
    logic [23:0] i_frame_time_us = 0;
    logic [17:0] i_target_fps = 0;
    logic        i_fg_active = 0, i_rr_active = 0;
    logic [3:0]  i_fg_multiplier = 0;
    logic [7:0]  i_tier_index = 0;
    logic        i_cfg_valid = 0;
    logic [2:0]  i_cfg_index = 0;
    logic [16:0] i_cfg_data = 0;
    logic        o_stall, o_valid, o_transitioned, o_locked_flag, o_active_flag;
    logic        o_cfg_ready;
    logic [3:0]  o_tier;
    logic [10:0] o_tier_k;
    logic [18:0] o_quality;

    tier_scoreboard sb = new();
    bit stim_done = 0;

    render_scale_tier_governor_core dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // output side: random stall, check at rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check({o_transitioned, o_tier, o_tier_k, o_quality, o_locked_flag,
                      o_active_flag});
    end

    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            @(negedge i_clk);
            if (n != 0) begin
                i_stall <= 1;
                repeat (n) @(negedge i_clk);
                i_stall <= 0;
            end
        end
    end

    // valid stays up across back to back transactions, drops for a gap or a register write
    task automatic send_op(logic [2:0] op, logic [23:0] ft, logic [17:0] fps, bit fg,
                           logic [3:0] fgm, bit rr, logic [7:0] ti, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1; i_op <= op; i_frame_time_us <= ft; i_target_fps <= fps;
        i_fg_active <= fg; i_fg_multiplier <= fgm; i_rr_active <= rr; i_tier_index <= ti;
        do @(posedge i_clk); while (o_stall);
        sb.note_op(op, ft, fps, fg, fgm, rr, ti);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [16:0] v);
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // frame time around the target interval so counters run both ways
    function automatic logic [23:0] pick_ft(logic [17:0] fps);
        logic [63:0] base;
        base = fps == 0 ? 6060 : 256000000 / fps;
        case ($urandom_range(0, 9))
            0: return 24'($urandom);
            1: return 24'($urandom_range(30000, 120000));
            2: return 24'hFFFFFF;
            default: return 24'(base * $urandom_range(60, 150) / 100);
        endcase
    endfunction

    task automatic random_phase(int cnt, bit gaps);
        logic [17:0] fps;
        logic [2:0]  op;
        for (int i = 0; i < cnt; i++) begin
            fps = $urandom_range(0, 4) == 0 ? 18'd0 :
                  ($urandom_range(0, 5) == 0 ? 18'($urandom) : 18'($urandom_range(7680, 61440)));
            op = $urandom_range(0, 39) < 34 ? OP_FRAME : 3'($urandom_range(1, 7));
            send_op(op, pick_ft(fps), fps, 1'($urandom_range(0, 1)), 4'($urandom),
                    $urandom_range(0, 5) == 0, 8'($urandom), gaps);
        end
    endtask

    initial begin
        int limit_frames;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // directed: field extremes and each op
        send_op(OP_FRAME, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_FRAME, 24'hFFFFFF, 18'h3FFFF, 1, 4'hF, 1, 8'hFF, 0);
        send_op(OP_FORCE, 0, 0, 0, 0, 0, 8'hFF, 0);
        send_op(OP_FORCE, 0, 0, 0, 0, 0, 1, 0);
        send_op(OP_LOCK, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_FRAME, 1000, 15360, 0, 0, 1, 0, 0);
        send_op(OP_FORCE, 0, 0, 0, 0, 0, 2, 0);
        send_op(OP_UNLOCK, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_SHUTDOWN, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_FRAME, 5000, 0, 0, 0, 1, 0, 0);
        send_op(OP_FORCE, 0, 0, 0, 0, 0, 3, 0);
        send_op(OP_RESTART, 0, 0, 0, 0, 0, 0, 0);
        send_op(3'd6, 0, 0, 0, 0, 0, 0, 0);
        send_op(3'd7, 0, 0, 0, 0, 0, 0, 0);
        // quality floor climb, then spikes on transitions to lock
        write_cfg(CFG_SCALE, 17'd4000);
        write_cfg(CFG_KMAX, 17'd1216);
        write_cfg(CFG_DOWN_FRAMES, 17'd1);
        write_cfg(CFG_UP_FRAMES, 17'd1);
        send_op(OP_FRAME, 24'd6060, 0, 0, 0, 1, 0, 0);
        for (int i = 0; i < 4; i++)
            send_op(OP_FRAME, 24'd40000, 0, 0, 0, 0, 0, 0);
        send_op(OP_FRAME, 24'd40000, 0, 0, 0, 0, 0, 0);
        send_op(OP_UNLOCK, 0, 0, 0, 0, 0, 0, 0);
        // zero ratios, extreme registers
        write_cfg(CFG_DOWN_THR, 17'd0);
        write_cfg(CFG_UP_THR, 17'd0);
        write_cfg(CFG_START, 17'hF);
        write_cfg(CFG_SCALE, 17'h1FFFF);
        send_op(OP_RESTART, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_FRAME, 24'hFFFFFF, 0, 1, 4'd2, 0, 0, 0);
        write_cfg(CFG_KMAX, 17'd256);
        send_op(OP_FRAME, 24'd100, 0, 0, 0, 1, 0, 0);
        write_cfg(CFG_KMAX, 17'd100);
        send_op(OP_FORCE, 0, 0, 0, 0, 0, 8'd5, 0);
        // random phases across register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_cfg(CFG_SCALE, RST_SCALE); write_cfg(CFG_KMAX, 17'(RST_KMAX));
                    write_cfg(CFG_DOWN_FRAMES, 17'd2); write_cfg(CFG_UP_FRAMES, 17'd3);
                    write_cfg(CFG_DOWN_THR, RST_DOWN_THR); write_cfg(CFG_UP_THR, RST_UP_THR);
                    write_cfg(CFG_START, 17'd1);
                end
                7: begin
                    write_cfg(CFG_DOWN_FRAMES, 17'd1023); write_cfg(CFG_UP_FRAMES, 17'd1023);
                    write_cfg(CFG_DOWN_THR, 17'h1FFFF); write_cfg(CFG_UP_THR, 17'd1);
                end
                default: begin
                    write_cfg(CFG_SCALE, 17'($urandom_range(0, 65536)));
                    write_cfg(CFG_KMAX, 17'($urandom_range(256, 1216)));
                    limit_frames = $urandom_range(1, 4);
                    write_cfg(CFG_DOWN_FRAMES, 17'(limit_frames));
                    write_cfg(CFG_UP_FRAMES, 17'($urandom_range(1, 5)));
                    write_cfg(CFG_DOWN_THR, 17'($urandom_range(40000, 90000)));
                    write_cfg(CFG_UP_THR, 17'($urandom_range(50000, 100000)));
                    write_cfg(CFG_START, 17'($urandom_range(0, 15)));
                end
            endcase
            send_op(OP_RESTART, 0, 0, 0, 0, 0, 0, 1);
            random_phase(115, ph != 3);
        end
        i_valid <= 0;
        stim_done = 1;
    end

    initial begin
        while (!(stim_done && sb.pending.size() == 0)) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end
endmodule
